// File: hdl/erv_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the Euler rotation block.
package erv_pkg;

    localparam int TURN_UNITS    = 46080;  // 360 degrees, 7 fraction bits
    localparam int QUARTER_UNITS = 11520;  // 90 degrees, 7 fraction bits
    localparam int REM_W         = 14;     // remainder within a quadrant
    localparam int QUAD_W        = 2;
    localparam int CORDIC_STEPS  = 24;
    localparam int XY_W          = 33;     // CORDIC x and y, 30 fraction bits
    localparam int Z_W           = 32;     // CORDIC angle, degrees, 22 fraction bits
    localparam int Z_SHIFT       = 15;     // 7 to 22 fraction bits
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [XY_W-1:0] CORDIC_ONE  = 33'sd1073741824;

    typedef enum logic [QUAD_W-1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    // atan(2^-i) in degrees with 22 fraction bits
    function automatic logic signed [Z_W-1:0] atan_deg(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = 32'sd188743680;
            1:  v = 32'sd111421900;
            2:  v = 32'sd58872272;
            3:  v = 32'sd29884485;
            4:  v = 32'sd15000234;
            5:  v = 32'sd7507429;
            6:  v = 32'sd3754631;
            7:  v = 32'sd1877430;
            8:  v = 32'sd938729;
            9:  v = 32'sd469366;
            10: v = 32'sd234683;
            11: v = 32'sd117342;
            12: v = 32'sd58671;
            13: v = 32'sd29335;
            14: v = 32'sd14668;
            15: v = 32'sd7334;
            16: v = 32'sd3667;
            17: v = 32'sd1833;
            18: v = 32'sd917;
            19: v = 32'sd458;
            20: v = 32'sd229;
            21: v = 32'sd115;
            22: v = 32'sd57;
            23: v = 32'sd29;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/erv_front.sv
// Front end: accepts beats, reduces angles modulo one turn and splits them into quadrants.
module erv_front #(
    parameter int ANGLE_BITS = 16,
    parameter int VEC_BITS   = 24,
    parameter int QDEPTH     = 6,
    parameter int ENTRY_W    = 120
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic signed [ANGLE_BITS-1:0] yaw_deg,
    input  logic signed [ANGLE_BITS-1:0] pitch_deg,
    input  logic signed [ANGLE_BITS-1:0] roll_deg,
    input  logic signed [VEC_BITS-1:0]   vec_x,
    input  logic signed [VEC_BITS-1:0]   vec_y,
    input  logic signed [VEC_BITS-1:0]   vec_z,
    input  logic                         pop,
    output logic                         push,
    output logic [ENTRY_W-1:0]           push_data
);

    localparam int S   = (ANGLE_BITS > 15) ? ANGLE_BITS - 15 : 0;
    localparam int RW  = S + 17;
    localparam int NR  = S + 1;
    localparam int CW  = $clog2(QDEPTH + 1);
    localparam logic [RW-1:0] OFFSET = RW'(erv_pkg::TURN_UNITS) << S;

    logic                accept;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [NR+1:0]       vld_reg;
    logic [RW-1:0]       u_reg   [0:NR][0:2];
    logic [VEC_BITS-1:0] vec_reg [0:NR][0:2];
    logic [erv_pkg::REM_W-1:0] rem_reg [0:2];
    erv_pkg::quad_t      quad_reg [0:2];
    logic [VEC_BITS-1:0] vo_reg  [0:2];
    logic signed [ANGLE_BITS-1:0] ang [0:2];

    assign ang[0] = yaw_deg;
    assign ang[1] = pitch_deg;
    assign ang[2] = roll_deg;

    assign s_tready = (cnt_reg < CW'(QDEPTH));
    assign accept   = s_tvalid && s_tready;

    // credits cover every item in the front and in the queue
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (!accept && pop)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            vld_reg <= {vld_reg[NR:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            u_reg[0][a] <= RW'({{(RW-ANGLE_BITS){ang[a][ANGLE_BITS-1]}}, ang[a]}) + OFFSET;
        end
        vec_reg[0][0] <= vec_x;
        vec_reg[0][1] <= vec_y;
        vec_reg[0][2] <= vec_z;
    end

    // one conditional subtract of a shifted turn per stage
    for (genvar k = 0; k < NR; k++)
    begin : g_red
        localparam logic [RW-1:0] SUB = RW'(erv_pkg::TURN_UNITS) << (S - k);
        always_ff @(posedge clk)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (u_reg[k][a] >= SUB)
                begin
                    u_reg[k+1][a] <= u_reg[k][a] - SUB;
                end
                else
                begin
                    u_reg[k+1][a] <= u_reg[k][a];
                end
                vec_reg[k+1][a] <= vec_reg[k][a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (u_reg[NR][a][15:0] >= 16'(3 * erv_pkg::QUARTER_UNITS))
            begin
                quad_reg[a] <= erv_pkg::QUAD_3;
                rem_reg[a]  <= erv_pkg::REM_W'(u_reg[NR][a][15:0]
                                               - 16'(3 * erv_pkg::QUARTER_UNITS));
            end
            else if (u_reg[NR][a][15:0] >= 16'(2 * erv_pkg::QUARTER_UNITS))
            begin
                quad_reg[a] <= erv_pkg::QUAD_2;
                rem_reg[a]  <= erv_pkg::REM_W'(u_reg[NR][a][15:0]
                                               - 16'(2 * erv_pkg::QUARTER_UNITS));
            end
            else if (u_reg[NR][a][15:0] >= 16'(erv_pkg::QUARTER_UNITS))
            begin
                quad_reg[a] <= erv_pkg::QUAD_1;
                rem_reg[a]  <= erv_pkg::REM_W'(u_reg[NR][a][15:0]
                                               - 16'(erv_pkg::QUARTER_UNITS));
            end
            else
            begin
                quad_reg[a] <= erv_pkg::QUAD_0;
                rem_reg[a]  <= erv_pkg::REM_W'(u_reg[NR][a][15:0]);
            end
            vo_reg[a] <= vec_reg[NR][a];
        end
    end

    assign push      = vld_reg[NR+1];
    assign push_data = {vo_reg[2], vo_reg[1], vo_reg[0],
                        quad_reg[2], quad_reg[1], quad_reg[0],
                        rem_reg[2], rem_reg[1], rem_reg[0]};

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QDEPTH))
        else $error("front credit count above queue depth");
`endif

endmodule

// File: hdl/erv_queue.sv
// Short queue between the front end and the rotation back end.
module erv_queue #(
    parameter int ENTRY_W = 120,
    parameter int DEPTH   = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [ENTRY_W-1:0] push_data,
    input  logic               pop,
    output logic [ENTRY_W-1:0] head,
    output logic               empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [ENTRY_W-1:0] mem_reg [0:DEPTH-1];
    logic [PW-1:0]      wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]      count_reg, count_next;

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    assign head  = mem_reg[rd_reg];
    assign empty = (count_reg == '0);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CW'(DEPTH)))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue read while empty");
`endif

endmodule

// File: hdl/erv_cordic.sv
// Pipelined degree-domain CORDIC giving sine and cosine of a quadrant-split angle.
module erv_cordic #(
    parameter int TRIG_BITS = 16
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [erv_pkg::REM_W-1:0]       rem,
    input  erv_pkg::quad_t                  quad,
    output logic signed [TRIG_BITS+1:0]     sin_o,
    output logic signed [TRIG_BITS+1:0]     cos_o
);

    localparam int N  = erv_pkg::CORDIC_STEPS;
    localparam int XW = erv_pkg::XY_W;
    localparam int ZW = erv_pkg::Z_W;
    localparam int TW = TRIG_BITS + 2;
    localparam logic [30:0] HALF = 31'(1) << (29 - TRIG_BITS);

    logic signed [XW-1:0] x_reg [0:N-1];
    logic signed [XW-1:0] y_reg [0:N-1];
    logic signed [ZW-1:0] z_reg [0:N-1];
    erv_pkg::quad_t       q_reg [0:N-1];
    logic [30:0]          cx, cy, rx, ry;
    logic [TRIG_BITS:0]   c_mag, s_mag;

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        logic signed [XW-1:0] xi, yi;
        logic signed [ZW-1:0] zi;
        erv_pkg::quad_t       qi;
        if (i == 0)
        begin : g_first
            assign xi = erv_pkg::CORDIC_GAIN;
            assign yi = '0;
            assign zi = ZW'({1'b0, rem}) <<< erv_pkg::Z_SHIFT;
            assign qi = quad;
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign qi = q_reg[i-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!zi[ZW-1])
                begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    z_reg[i] <= zi - erv_pkg::atan_deg(i);
                end
                else
                begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    z_reg[i] <= zi + erv_pkg::atan_deg(i);
                end
                q_reg[i] <= qi;
            end
        end
    end

    // clamp to [0, 1.0] and round to the trig fraction width
    always_comb
    begin
        if (x_reg[N-1][XW-1])
        begin
            cx = '0;
        end
        else if (x_reg[N-1] > erv_pkg::CORDIC_ONE)
        begin
            cx = 31'(erv_pkg::CORDIC_ONE);
        end
        else
        begin
            cx = x_reg[N-1][30:0];
        end
        if (y_reg[N-1][XW-1])
        begin
            cy = '0;
        end
        else if (y_reg[N-1] > erv_pkg::CORDIC_ONE)
        begin
            cy = 31'(erv_pkg::CORDIC_ONE);
        end
        else
        begin
            cy = y_reg[N-1][30:0];
        end
        rx    = cx + HALF;
        ry    = cy + HALF;
        c_mag = rx[30:30-TRIG_BITS];
        s_mag = ry[30:30-TRIG_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (q_reg[N-1])
                erv_pkg::QUAD_0:
                begin
                    sin_o <= TW'(s_mag);
                    cos_o <= TW'(c_mag);
                end
                erv_pkg::QUAD_1:
                begin
                    sin_o <= TW'(c_mag);
                    cos_o <= -TW'(s_mag);
                end
                erv_pkg::QUAD_2:
                begin
                    sin_o <= -TW'(s_mag);
                    cos_o <= -TW'(c_mag);
                end
                erv_pkg::QUAD_3:
                begin
                    sin_o <= -TW'(c_mag);
                    cos_o <= TW'(s_mag);
                end
                default:
                begin
                    sin_o <= '0;
                    cos_o <= '0;
                end
            endcase
        end
    end

endmodule

// File: hdl/erv_back.sv
// Back end: sine/cosine units, rotation matrix build and matrix-vector product.
module erv_back #(
    parameter int VEC_BITS  = 24,
    parameter int TRIG_BITS = 16,
    parameter int ENTRY_W   = 120
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ENTRY_W-1:0]         head,
    input  logic                       empty,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic signed [VEC_BITS-1:0] rot_x,
    output logic signed [VEC_BITS-1:0] rot_y,
    output logic signed [VEC_BITS-1:0] rot_z
);

    localparam int RMW  = erv_pkg::REM_W;
    localparam int QW   = erv_pkg::QUAD_W;
    localparam int QOFF = 3 * RMW;
    localparam int VOFF = 3 * RMW + 3 * QW;
    localparam int LC   = erv_pkg::CORDIC_STEPS + 1;
    localparam int NB   = LC + 6;
    localparam int NV   = LC + 3;
    localparam int TSW  = TRIG_BITS + 2;
    localparam int RW2  = TSW + 1;
    localparam int PRW  = RW2 + VEC_BITS;
    localparam int AW   = PRW + 2;
    localparam int SHW  = AW - TRIG_BITS;
    localparam logic signed [AW-1:0]  ACC_HALF = AW'(1) <<< (TRIG_BITS - 1);
    localparam logic signed [SHW-1:0] SAT_HI = SHW'((64'(1) << (VEC_BITS - 1)) - 1);
    localparam logic signed [SHW-1:0] SAT_LO = -SHW'(64'(1) << (VEC_BITS - 1));

    function automatic logic signed [TSW-1:0] tmul(input logic signed [TSW-1:0] a,
                                                   input logic signed [TSW-1:0] b);
        logic signed [2*TSW-1:0] p;
        p = a * b;
        p = p + ((2*TSW)'(1) <<< (TRIG_BITS - 1));
        return TSW'(p >>> TRIG_BITS);
    endfunction

    logic                 en;
    logic [NB-1:0]        vld_reg;
    logic signed [VEC_BITS-1:0] vec_reg [0:NV-1][0:2];
    logic signed [TSW-1:0] sn [0:2];
    logic signed [TSW-1:0] cs [0:2];

    // stage one: products of two trig values and copies of single trig values
    logic signed [TSW-1:0] cysp1_reg, sysp1_reg, cycp1_reg, sycp1_reg, sycr1_reg, sysr1_reg;
    logic signed [TSW-1:0] cycr1_reg, cysr1_reg, cpsr1_reg, cpcr1_reg, sp1_reg, sr1_reg;
    logic signed [TSW-1:0] cr1_reg;
    // stage two: terms of the matrix entries
    logic signed [TSW-1:0] t00_reg, t01a_reg, t01b_reg, t02a_reg, t02b_reg, t10_reg;
    logic signed [TSW-1:0] t11a_reg, t11b_reg, t12a_reg, t12b_reg, t20_reg, t21_reg, t22_reg;
    // stage three: matrix, stage four: products, stage five: sums
    logic signed [RW2-1:0] r_reg [0:2][0:2];
    logic signed [PRW-1:0] p_reg [0:2][0:2];
    logic signed [SHW-1:0] s_reg [0:2];
    logic signed [VEC_BITS-1:0] o_reg [0:2];
    logic signed [AW-1:0]  acc [0:2];

    assign en  = !vld_reg[NB-1] || m_tready;
    assign pop = en && !empty;

    for (genvar a = 0; a < 3; a++)
    begin : g_trig
        erv_cordic #(
            .TRIG_BITS (TRIG_BITS)
        ) u_cordic (
            .clk   (clk),
            .en    (en),
            .rem   (head[a*RMW +: RMW]),
            .quad  (erv_pkg::quad_t'(head[QOFF + a*QW +: QW])),
            .sin_o (sn[a]),
            .cos_o (cs[a])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NB-2:0], pop};
        end
    end

    // carry the vector alongside the angle path
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                vec_reg[0][a] <= head[VOFF + a*VEC_BITS +: VEC_BITS];
                for (int k = 1; k < NV; k++)
                begin
                    vec_reg[k][a] <= vec_reg[k-1][a];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cysp1_reg <= tmul(cs[0], sn[1]);
            sysp1_reg <= tmul(sn[0], sn[1]);
            cycp1_reg <= tmul(cs[0], cs[1]);
            sycp1_reg <= tmul(sn[0], cs[1]);
            sycr1_reg <= tmul(sn[0], cs[2]);
            sysr1_reg <= tmul(sn[0], sn[2]);
            cycr1_reg <= tmul(cs[0], cs[2]);
            cysr1_reg <= tmul(cs[0], sn[2]);
            cpsr1_reg <= tmul(cs[1], sn[2]);
            cpcr1_reg <= tmul(cs[1], cs[2]);
            sp1_reg   <= sn[1];
            sr1_reg   <= sn[2];
            cr1_reg   <= cs[2];

            t00_reg  <= cycp1_reg;
            t01a_reg <= tmul(cysp1_reg, sr1_reg);
            t01b_reg <= sycr1_reg;
            t02a_reg <= tmul(cysp1_reg, cr1_reg);
            t02b_reg <= sysr1_reg;
            t10_reg  <= sycp1_reg;
            t11a_reg <= tmul(sysp1_reg, sr1_reg);
            t11b_reg <= cycr1_reg;
            t12a_reg <= tmul(sysp1_reg, cr1_reg);
            t12b_reg <= cysr1_reg;
            t20_reg  <= -sp1_reg;
            t21_reg  <= cpsr1_reg;
            t22_reg  <= cpcr1_reg;

            r_reg[0][0] <= RW2'(t00_reg);
            r_reg[0][1] <= RW2'(t01a_reg) - RW2'(t01b_reg);
            r_reg[0][2] <= RW2'(t02a_reg) + RW2'(t02b_reg);
            r_reg[1][0] <= RW2'(t10_reg);
            r_reg[1][1] <= RW2'(t11a_reg) + RW2'(t11b_reg);
            r_reg[1][2] <= RW2'(t12a_reg) - RW2'(t12b_reg);
            r_reg[2][0] <= RW2'(t20_reg);
            r_reg[2][1] <= RW2'(t21_reg);
            r_reg[2][2] <= RW2'(t22_reg);

            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p_reg[i][j] <= PRW'(r_reg[i][j]) * PRW'(vec_reg[NV-1][j]);
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = AW'(p_reg[i][0]) + AW'(p_reg[i][1]) + AW'(p_reg[i][2]) + ACC_HALF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s_reg[i] <= SHW'(acc[i] >>> TRIG_BITS);
                // saturate to the vector range
                if (s_reg[i] > SAT_HI)
                begin
                    o_reg[i] <= VEC_BITS'(SAT_HI);
                end
                else if (s_reg[i] < SAT_LO)
                begin
                    o_reg[i] <= VEC_BITS'(SAT_LO);
                end
                else
                begin
                    o_reg[i] <= VEC_BITS'(s_reg[i]);
                end
            end
        end
    end

    assign m_tvalid = vld_reg[NB-1];
    assign rot_x    = o_reg[0];
    assign rot_y    = o_reg[1];
    assign rot_z    = o_reg[2];

`ifndef SYNTHESIS
    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("back pipeline moved while stalled");
`endif

endmodule

// File: hdl/euler_rotate_vector.sv
// Euler-angle (ZYX) rotation of a three-axis vector, top level.
//
// Slave stream: one beat carries yaw, pitch and roll in signed degrees with
// 7 fraction bits and a Q7.16 vector. Master stream: one beat carries the
// rotated vector R = Rz(yaw)*Ry(pitch)*Rx(roll) times vec, saturated.
// Every input beat gives exactly one output beat, in order.
// Throughput: one beat per cycle while the master side does not stall. A
// beat passes the angle reduction front end (input register, conditional
// subtract stages, quadrant split), the queue and the back end (24 CORDIC
// stages, rounding, three matrix stages, the product, the sum and the
// saturating output register).
// When the master side stalls, the back end holds; the front end keeps
// accepting until the queue credit runs out, so s_tready depends only on
// registered state. Reset clears all valid bits and queue pointers; no
// memory clearing pass is needed.
module euler_rotate_vector #(
    parameter int ANGLE_BITS = 16,
    parameter int VEC_BITS   = 24,
    parameter int TRIG_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // yaw_deg, pitch_deg, roll_deg, vec_x, vec_y, vec_z, zero fill
    input  logic [((3*ANGLE_BITS+3*VEC_BITS+7)/8)*8-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // rot_x, rot_y, rot_z, zero fill
    output logic [((3*VEC_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int S       = (ANGLE_BITS > 15) ? ANGLE_BITS - 15 : 0;
    localparam int QDEPTH  = S + 5;
    localparam int ENTRY_W = 3 * erv_pkg::REM_W + 3 * erv_pkg::QUAD_W + 3 * VEC_BITS;
    localparam int OUT_W   = ((3*VEC_BITS+7)/8)*8;
    localparam int AB3     = 3 * ANGLE_BITS;

    logic               push, pop, empty;
    logic [ENTRY_W-1:0] push_data, head;
    logic signed [VEC_BITS-1:0] rot_x, rot_y, rot_z;

    erv_front #(
        .ANGLE_BITS (ANGLE_BITS),
        .VEC_BITS   (VEC_BITS),
        .QDEPTH     (QDEPTH),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .yaw_deg   (s_tdata[0 +: ANGLE_BITS]),
        .pitch_deg (s_tdata[ANGLE_BITS +: ANGLE_BITS]),
        .roll_deg  (s_tdata[2*ANGLE_BITS +: ANGLE_BITS]),
        .vec_x     (s_tdata[AB3 +: VEC_BITS]),
        .vec_y     (s_tdata[AB3 + VEC_BITS +: VEC_BITS]),
        .vec_z     (s_tdata[AB3 + 2*VEC_BITS +: VEC_BITS]),
        .pop       (pop),
        .push      (push),
        .push_data (push_data)
    );

    erv_queue #(
        .ENTRY_W (ENTRY_W),
        .DEPTH   (QDEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    erv_back #(
        .VEC_BITS  (VEC_BITS),
        .TRIG_BITS (TRIG_BITS),
        .ENTRY_W   (ENTRY_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .rot_x    (rot_x),
        .rot_y    (rot_y),
        .rot_z    (rot_z)
    );

    assign m_tdata = OUT_W'({rot_z, rot_y, rot_x});

endmodule
